// File: design/frx_pkg.sv
// ----------------------------------------------------------------------------
// frx_pkg: shared types and constants of the frame receiver
// Register map, source class codes, result word layout and classification.
// ----------------------------------------------------------------------------
package frx_pkg;

  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  localparam logic [7:0]  START_RESET = 8'h68;
  localparam logic [15:0] HDR_LEN     = 16'd8;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_START_BYTE    = 3'd0,
    REG_PANEL_ADDR    = 3'd1,
    REG_CTRL_ADDR     = 3'd2,
    REG_CTRL_TYPE     = 3'd3,
    REG_MODULE_ADDR   = 3'd4,
    REG_MODULE_TYPE   = 3'd5,
    REG_THERMO_ADDR   = 3'd6,
    REG_THERMO_TYPE   = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    CLS_PANEL      = 3'd0,
    CLS_CONTROLLER = 3'd1,
    CLS_MODULE     = 3'd2,
    CLS_THERMOSTAT = 3'd3,
    CLS_OTHER      = 3'd4
  } src_cls_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] panel_address;
    logic [7:0] controller_address;
    logic [7:0] controller_type;
    logic [7:0] module_address;
    logic [7:0] module_type;
    logic [7:0] thermostat_address;
    logic [7:0] thermostat_type;
  } cfg_regs_t;

  typedef struct packed {
    logic        frame_ok;
    src_cls_t    source_class;
    logic [7:0]  source_addr;
    logic [7:0]  frame_kind;
    logic [14:0] frame_length;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } res_push_t;

  // Panel wins on address alone; the others need address and type.
  function automatic src_cls_t classify(cfg_regs_t c, logic [7:0] src, logic [7:0] kind);
    src_cls_t cls;
    if (src == c.panel_address) begin
      cls = CLS_PANEL;
    end else if (src == c.controller_address && kind == c.controller_type) begin
      cls = CLS_CONTROLLER;
    end else if (src == c.module_address && kind == c.module_type) begin
      cls = CLS_MODULE;
    end else if (src == c.thermostat_address && kind == c.thermostat_type) begin
      cls = CLS_THERMOSTAT;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

endpackage

// File: design/frx_cfg.sv
// ----------------------------------------------------------------------------
// frx_cfg: configuration register file
// APB-style write and read of the eight 8-bit control registers.
// ----------------------------------------------------------------------------
module frx_cfg import frx_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_regs_t          cfg
);

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;
  reg_idx_t  idx;
  logic      wr_en;
  logic [7:0] rd_byte;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_START_BYTE:  cfg_nxt.start_byte         = pwdata[7:0];
        REG_PANEL_ADDR:  cfg_nxt.panel_address      = pwdata[7:0];
        REG_CTRL_ADDR:   cfg_nxt.controller_address = pwdata[7:0];
        REG_CTRL_TYPE:   cfg_nxt.controller_type    = pwdata[7:0];
        REG_MODULE_ADDR: cfg_nxt.module_address     = pwdata[7:0];
        REG_MODULE_TYPE: cfg_nxt.module_type        = pwdata[7:0];
        REG_THERMO_ADDR: cfg_nxt.thermostat_address = pwdata[7:0];
        REG_THERMO_TYPE: cfg_nxt.thermostat_type    = pwdata[7:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_BYTE:  rd_byte = cfg_r.start_byte;
      REG_PANEL_ADDR:  rd_byte = cfg_r.panel_address;
      REG_CTRL_ADDR:   rd_byte = cfg_r.controller_address;
      REG_CTRL_TYPE:   rd_byte = cfg_r.controller_type;
      REG_MODULE_ADDR: rd_byte = cfg_r.module_address;
      REG_MODULE_TYPE: rd_byte = cfg_r.module_type;
      REG_THERMO_ADDR: rd_byte = cfg_r.thermostat_address;
      REG_THERMO_TYPE: rd_byte = cfg_r.thermostat_type;
      default:         rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(PDATA_W-8){1'b0}}, rd_byte};
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{start_byte: START_RESET, default: 8'h00};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: design/frx_parse.sv
// ----------------------------------------------------------------------------
// frx_parse: frame tracker
// Start-byte hunt, header capture, byte count and running XOR.
// ----------------------------------------------------------------------------
module frx_parse import frx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_regs_t  cfg,
  input  logic       byte_take,
  input  logic [7:0] rx_byte,
  output logic       will_emit,
  output res_push_t  res_push
);

  logic        phase_r,  phase_nxt;
  logic [14:0] pos_r,    pos_nxt;
  logic [15:0] decl_r,   decl_nxt;
  logic [7:0]  xor_r,    xor_nxt;
  logic [7:0]  src_r,    src_nxt;
  logic [7:0]  kind_r,   kind_nxt;
  logic [15:0] eff_len;
  logic [7:0]  kind_cur;

  // Length is settled by byte 2, so the close decision needs state only.
  assign eff_len   = (decl_r < HDR_LEN || decl_r[15]) ? HDR_LEN : decl_r;
  assign will_emit = phase_r && (pos_r >= 15'd7) && (({1'b0, pos_r} + 16'd1) >= eff_len);
  assign kind_cur  = (pos_r == 15'd7) ? rx_byte : kind_r;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    decl_nxt  = decl_r;
    xor_nxt   = xor_r;
    src_nxt   = src_r;
    kind_nxt  = kind_r;
    res_push.push             = 1'b0;
    res_push.res.frame_ok     = (xor_r == 8'd0);
    res_push.res.source_class = classify(cfg, src_r, kind_cur);
    res_push.res.source_addr  = src_r;
    res_push.res.frame_kind   = kind_cur;
    res_push.res.frame_length = eff_len[14:0];
    if (byte_take) begin
      if (!phase_r) begin
        if (rx_byte == cfg.start_byte) begin
          phase_nxt = 1'b1;
          pos_nxt   = 15'd1;
          xor_nxt   = rx_byte;
          decl_nxt  = 16'd0;
        end
      end else begin
        case (pos_r)
          15'd1:   decl_nxt = {decl_r[15:8], rx_byte};
          15'd2:   decl_nxt = {rx_byte, decl_r[7:0]};
          15'd4:   src_nxt  = rx_byte;
          15'd7:   kind_nxt = rx_byte;
          default: decl_nxt = decl_r;
        endcase
        if (will_emit) begin
          res_push.push = 1'b1;
          phase_nxt     = 1'b0;
          pos_nxt       = 15'd0;
          xor_nxt       = 8'd0;
        end else begin
          xor_nxt = xor_r ^ rx_byte;
          pos_nxt = pos_r + 15'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      pos_r   <= '0;
      decl_r  <= '0;
      xor_r   <= '0;
      src_r   <= '0;
      kind_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      decl_r  <= decl_nxt;
      xor_r   <= xor_nxt;
      src_r   <= src_nxt;
      kind_r  <= kind_nxt;
    end
  end

endmodule

// File: design/frx_out.sv
// ----------------------------------------------------------------------------
// frx_out: result register
// Hold one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module frx_out import frx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_push_t res_push,
  input  logic      out_stall,
  output logic      blocked,
  output logic      out_valid,
  output result_t   res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign blocked = valid_r & out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
    if (res_push.push) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push.push) begin
      res_r <= res_push.res;
    end
  end

  assign out_valid = valid_r;
  assign res       = res_r;

endmodule

// File: design/frame_receiver_xor_check_top.sv
// ----------------------------------------------------------------------------
// frame_receiver_xor_check_top: length-prefixed frame receiver with XOR check
// Hunts for the start byte, tracks header and length, reports each frame.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock whenever in_stall is low, and
// every byte that it takes from in_rx_byte is folded into the frame tracker
// state in the cycle it is accepted, and the word for a finished frame sits in
// the result register from the next cycle on. in_stall rises only when the
// offered byte would close a frame while the previous result word is still
// held by a stalled downstream side; every other byte, including those that
// arrive while a result waits, is taken at once. Frames are opened by the
// configured start byte (0x68 after reset), carry their little-endian total
// length in header bytes 1 and 2 (below 8 or from 32768 up means 8), and are
// judged good when the XOR of every byte but the last is zero. The source
// class is matched against the configuration registers as they stand when
// the last byte arrives; write them only while no frame is in flight.
// ----------------------------------------------------------------------------
module frame_receiver_xor_check_top import frx_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // Byte input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  // Frame result
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_frame_ok,
  output logic [2:0]         out_source_class,
  output logic [7:0]         out_source_addr,
  output logic [7:0]         out_frame_kind,
  output logic [14:0]        out_frame_length,
  // Configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_regs_t cfg;
  res_push_t res_push;
  result_t   res;
  logic      will_emit;
  logic      blocked;
  logic      byte_take;

  // Stall only the byte that would need a free result register.
  assign in_stall  = will_emit & blocked;
  assign byte_take = in_valid & ~in_stall;

  frx_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  frx_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .byte_take (byte_take),
    .rx_byte   (in_rx_byte),
    .will_emit (will_emit),
    .res_push  (res_push)
  );

  frx_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .out_stall (out_stall),
    .blocked   (blocked),
    .out_valid (out_valid),
    .res       (res)
  );

  // Drive the result word fields out.
  assign out_frame_ok     = res.frame_ok;
  assign out_source_class = res.source_class;
  assign out_source_addr  = res.source_addr;
  assign out_frame_kind   = res.frame_kind;
  assign out_frame_length = res.frame_length;

endmodule

// File: design/frx_checker.sv
// ----------------------------------------------------------------------------
// frx_checker: port-level checks of the frame receiver
// Watches the byte and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module frx_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_source_class,
  input logic [14:0] out_frame_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_frame_length) && $stable(out_source_class))
    else $error("stalled result word changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("byte input stalled without a blocked result");

  a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_length >= 15'd8)
    else $error("frame length below header size");

  a_cls_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_source_class <= 3'd4)
    else $error("source class code out of range");

endmodule

bind frame_receiver_xor_check_top frx_checker u_frx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_source_class (out_source_class),
  .out_frame_length (out_frame_length)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of frame_receiver_xor_check_top
// Builds framed byte streams (good, corrupted, odd declared lengths, line
// noise), mirrors the frame tracker and source classifier in a local model,
// and checks every frame report field by field against the expected ones.
// ----------------------------------------------------------------------------
module tb import frx_pkg::*; ();

  // Generous ceiling: the slowest correct run stays far below it.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Length of the long downstream hold-off that fills the block.
  localparam int unsigned HOLD_CYCLES = 200;
  // Ceiling on the wait for reports that are still due.
  localparam int DRAIN_LIMIT = 5000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic               out_frame_ok;
  logic [2:0]         out_source_class;
  logic [7:0]         out_source_addr;
  logic [7:0]         out_frame_kind;
  logic [14:0]        out_frame_length;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  frame_receiver_xor_check_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_ok     (out_frame_ok),
    .out_source_class (out_source_class),
    .out_source_addr  (out_source_addr),
    .out_frame_kind   (out_frame_kind),
    .out_frame_length (out_frame_length),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Local copy of the register file and of the frame tracker.
  cfg_regs_t   shadow_regs;
  bit          trk_open;
  logic [14:0] trk_pos;
  logic [15:0] trk_len_field;
  logic [7:0]  trk_xor;
  logic [7:0]  trk_src;
  logic [7:0]  trk_kind;

  // Frame reports still owed by the block, oldest first.
  result_t frames_due [$];

  int          error_count;
  int          bytes_sent;
  int          frames_predicted;
  int unsigned cycle_count;
  bit          sender_idle;
  bit          sink_idle;
  bit          hold_req;
  int          hold_cnt;

  always #5 clk = ~clk;

  // Print one line per mismatch and count it.
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    error_count++;
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
  endtask

  function automatic src_cls_t class_of(input logic [7:0] src, input logic [7:0] kind);
    if (src == shadow_regs.panel_address) return CLS_PANEL;
    if (src == shadow_regs.controller_address && kind == shadow_regs.controller_type)
      return CLS_CONTROLLER;
    if (src == shadow_regs.module_address && kind == shadow_regs.module_type)
      return CLS_MODULE;
    if (src == shadow_regs.thermostat_address && kind == shadow_regs.thermostat_type)
      return CLS_THERMOSTAT;
    return CLS_OTHER;
  endfunction

  // Advance the frame tracker by one byte; return 1 when a frame closes.
  function automatic bit track_byte(input logic [7:0] b, output result_t rep);
    int p;
    int eff;
    rep = '0;
    if (!trk_open) begin
      if (b == shadow_regs.start_byte) begin
        trk_open      = 1'b1;
        trk_pos       = 15'd1;
        trk_xor       = b;
        trk_len_field = '0;
      end
      return 1'b0;
    end
    p = int'(trk_pos);
    case (p)
      1: trk_len_field[7:0]  = b;
      2: trk_len_field[15:8] = b;
      4: trk_src             = b;
      7: trk_kind            = b;
      default: ;
    endcase
    // Out-of-range declared lengths collapse to a bare header.
    if (trk_len_field < HDR_LEN || trk_len_field[15]) eff = int'(HDR_LEN);
    else eff = int'(trk_len_field);
    if (p >= HDR_LEN - 1 && p + 1 >= eff) begin
      rep.frame_ok     = (trk_xor == 8'h00);
      rep.source_class = class_of(trk_src, trk_kind);
      rep.source_addr  = trk_src;
      rep.frame_kind   = trk_kind;
      rep.frame_length = eff[14:0];
      trk_open = 1'b0;
      trk_pos  = '0;
      trk_xor  = '0;
      return 1'b1;
    end
    trk_xor = trk_xor ^ b;
    trk_pos = trk_pos + 15'd1;
    return 1'b0;
  endfunction

  // Offer one byte, hold it through stalls, and book it once accepted.
  task automatic send_byte(input logic [7:0] b);
    result_t rep;
    @(negedge clk);
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (track_byte(b, rep)) begin
      frames_due.insert(frames_due.size(), rep);
      frames_predicted++;
    end
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Wait for owed reports, then let the pipeline settle.
  task automatic drain();
    int n;
    n = 0;
    while (frames_due.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (8) @(negedge clk);
  endtask

  // Close any open frame and go quiet before touching registers.
  task automatic settle();
    while (trk_open) send_byte(8'h00);
    release_input();
    drain();
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_regs[63 - 8 * idx -: 8] = val;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_read(input reg_idx_t idx, output logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    val = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the whole register file, then read every register back.
  task automatic program_regs(input cfg_regs_t c);
    logic [PDATA_W-1:0] rd;
    settle();
    for (int i = 0; i < 8; i++) cfg_write(reg_idx_t'(i), c[63 - 8 * i -: 8]);
    for (int i = 0; i < 8; i++) begin
      cfg_read(reg_idx_t'(i), rd);
      if (rd !== {24'h0, c[63 - 8 * i -: 8]})
        flag_mismatch($sformatf("register %0d readback", i), rd, {24'h0, c[63 - 8 * i -: 8]});
    end
  endtask

  // Build one frame: byte 6 is the free byte that sets the XOR balance.
  task automatic send_frame(input logic [15:0] decl, input logic [7:0] src,
                            input logic [7:0] kind, input bit good);
    logic [7:0] fb [$];
    logic [7:0] x;
    logic [7:0] flip;
    int         len;
    if (decl < HDR_LEN || decl[15]) len = int'(HDR_LEN);
    else len = int'(decl);
    fb.insert(fb.size(), shadow_regs.start_byte);
    fb.insert(fb.size(), decl[7:0]);
    fb.insert(fb.size(), decl[15:8]);
    fb.insert(fb.size(), 8'($urandom));
    fb.insert(fb.size(), src);
    fb.insert(fb.size(), 8'($urandom));
    fb.insert(fb.size(), 8'h00);
    fb.insert(fb.size(), kind);
    for (int i = int'(HDR_LEN); i < len; i++) fb.insert(fb.size(), 8'($urandom));
    x = 8'h00;
    for (int i = 0; i <= len - 2; i++) if (i != 6) x ^= fb[i];
    flip  = 8'($urandom_range(1, 255));
    fb[6] = good ? x : x ^ flip;
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  function automatic logic [7:0] pick_src();
    case ($urandom_range(0, 4))
      0: return shadow_regs.panel_address;
      1: return shadow_regs.controller_address;
      2: return shadow_regs.module_address;
      3: return shadow_regs.thermostat_address;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 3))
      0: return shadow_regs.controller_type;
      1: return shadow_regs.module_type;
      2: return shadow_regs.thermostat_type;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly short frames; a few bare-header, huge and medium lengths.
  function automatic logic [15:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 15) return 16'($urandom_range(8, 24));
    if (r < 17) return 16'($urandom_range(0, 7));
    if (r < 18) return 16'($urandom_range(32768, 65535));
    return 16'($urandom_range(25, 120));
  endfunction

  // Line noise never carries the start byte, so it stays in the hunt.
  function automatic logic [7:0] noise_byte();
    logic [7:0] n;
    n = 8'($urandom);
    while (n == shadow_regs.start_byte) n = 8'($urandom);
    return n;
  endfunction

  task automatic run_random(input int byte_goal, input int frame_goal);
    int b0;
    int f0;
    b0 = bytes_sent;
    f0 = frames_predicted;
    while (bytes_sent - b0 < byte_goal || frames_predicted - f0 < frame_goal) begin
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) send_byte(noise_byte());
      send_frame(pick_len(), pick_src(), pick_kind(), $urandom_range(0, 3) != 0);
    end
  endtask

  function automatic cfg_regs_t random_regs();
    cfg_regs_t c;
    c = {$urandom, $urandom};
    return c;
  endfunction

  // Reset values: every address 0, so source 0 is panel and all else other.
  task automatic test_reset_defaults();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h67);
    send_byte(8'h69);
    send_frame(16'd8,     8'h00, 8'h00, 1'b1);
    send_frame(16'd0,     8'hFF, 8'hFF, 1'b1);
    send_frame(16'd7,     8'h00, 8'h5A, 1'b0);
    send_frame(16'd9,     8'h01, 8'h00, 1'b1);
    send_frame(16'h8000,  8'h80, 8'h7F, 1'b1);
    send_frame(16'hFFFF,  8'h00, 8'h80, 1'b0);
    send_frame(16'd16,    8'hA5, 8'h5A, 1'b0);
    send_frame(16'd10,    8'h00, 8'hC3, 1'b1);
  endtask

  // Lengths on both sides of each limit, streamed without gaps.
  task automatic test_length_extremes();
    sender_idle = 1'b0;
    send_frame(16'd8,    8'h3C, 8'hC3, 1'b1);
    send_frame(16'd7,    8'h3C, 8'hC3, 1'b0);
    send_frame(16'h8000, 8'h00, 8'h01, 1'b1);
    send_frame(16'h8008, 8'h00, 8'h01, 1'b0);
    send_frame(16'd40,   8'h3C, 8'h01, 1'b1);
    sender_idle = 1'b1;
  endtask

  task automatic test_class_priority();
    cfg_regs_t c;
    // Controller and module share an address; thermostat hides behind panel.
    c = '{start_byte: 8'h68, panel_address: 8'h10, controller_address: 8'h20,
          controller_type: 8'h30, module_address: 8'h20, module_type: 8'h31,
          thermostat_address: 8'h10, thermostat_type: 8'h40};
    program_regs(c);
    send_frame(16'd8,  8'h10, 8'h40, 1'b1);
    send_frame(16'd8,  8'h20, 8'h30, 1'b1);
    send_frame(16'd12, 8'h20, 8'h31, 1'b1);
    send_frame(16'd8,  8'h20, 8'h40, 1'b0);
    // Extremes: start byte 0x00, all-ones and all-zeros matches.
    c = '{start_byte: 8'h00, panel_address: 8'hFF, controller_address: 8'h00,
          controller_type: 8'hFF, module_address: 8'hFF, module_type: 8'h00,
          thermostat_address: 8'h00, thermostat_type: 8'h00};
    program_regs(c);
    send_byte(8'h01);
    send_frame(16'd8,  8'h00, 8'h00, 1'b1);
    send_frame(16'd9,  8'h00, 8'hFF, 1'b1);
    send_frame(16'd8,  8'hFF, 8'h00, 1'b0);
    send_frame(16'd8,  8'h01, 8'h00, 1'b1);
    c = '{start_byte: 8'hFF, panel_address: 8'h00, controller_address: 8'hFF,
          controller_type: 8'hFF, module_address: 8'hFF, module_type: 8'hFF,
          thermostat_address: 8'hFF, thermostat_type: 8'hFF};
    program_regs(c);
    send_byte(8'hFE);
    send_frame(16'd8,  8'hFF, 8'hFF, 1'b1);
    send_frame(16'd11, 8'h00, 8'hFF, 1'b1);
  endtask

  task automatic test_random_traffic();
    repeat (3) begin
      program_regs(random_regs());
      run_random(60, 3);
    end
  endtask

  // Hold the result side off while short frames keep coming in.
  task automatic test_backpressure();
    program_regs(random_regs());
    hold_req = 1'b1;
    repeat (6) send_frame(16'd8, pick_src(), pick_kind(), $urandom_range(0, 1) != 0);
    while (hold_req) @(negedge clk);
    run_random(30, 2);
  endtask

  task automatic test_steady_stream();
    program_regs(random_regs());
    sender_idle = 1'b0;
    sink_idle   = 1'b0;
    run_random(80, 4);
  endtask

  // Downstream pacing: random stall bursts, or one long hold on request.
  always begin : sink_pacing
    @(negedge clk);
    if (hold_req) begin
      out_stall <= 1'b1;
      for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(negedge clk);
      hold_req = 1'b0;
      out_stall <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 9)) @(negedge clk);
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted report word with the oldest one owed.
  always @(posedge clk) begin : check_reports
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        flag_mismatch("report word with none owed", 32'd1, 32'd0);
      end else begin
        want = frames_due.pop_front();
        if (out_frame_ok !== want.frame_ok)
          flag_mismatch("frame_ok", 32'(out_frame_ok), 32'(want.frame_ok));
        if (out_source_class !== want.source_class)
          flag_mismatch("source_class", 32'(out_source_class), 32'(want.source_class));
        if (out_source_addr !== want.source_addr)
          flag_mismatch("source_addr", 32'(out_source_addr), 32'(want.source_addr));
        if (out_frame_kind !== want.frame_kind)
          flag_mismatch("frame_kind", 32'(out_frame_kind), 32'(want.frame_kind));
        if (out_frame_length !== want.frame_length)
          flag_mismatch("frame_length", 32'(out_frame_length), 32'(want.frame_length));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL frame_receiver_xor_check_top");
      $finish;
    end
  end

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_rx_byte  = 8'h00;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    sender_idle = 1'b1;
    sink_idle   = 1'b1;
    hold_req    = 1'b0;
    shadow_regs = '{start_byte: START_RESET, default: 8'h00};
    trk_open    = 1'b0;
    trk_pos     = '0;
    trk_len_field = '0;
    trk_xor     = '0;
    trk_src     = '0;
    trk_kind    = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_length_extremes();
    test_class_priority();
    test_random_traffic();
    test_backpressure();
    test_steady_stream();

    release_input();
    drain();
    if (frames_due.size() != 0)
      flag_mismatch("reports never delivered", 32'(frames_due.size()), 32'd0);
    if (error_count == 0) begin
      $display("PASS frame_receiver_xor_check_top");
    end else begin
      $display("FAIL frame_receiver_xor_check_top");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/frx_pkg.sv
design/frx_cfg.sv
design/frx_parse.sv
design/frx_out.sv
design/frame_receiver_xor_check_top.sv
design/frx_checker.sv
dv/tb.sv
